>>> rtl/core/factor_model_residual_moments_defines.svh
// Assertion macros for the residual moments block.
// Used by the port checker; expects clk_i and rst_ni in scope.
`ifndef FACTOR_MODEL_RESIDUAL_MOMENTS_DEFINES_SVH
`define FACTOR_MODEL_RESIDUAL_MOMENTS_DEFINES_SVH

// same-cycle implication
`define FMRM_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FMRM_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/fmrm_pkg.sv
// Shared types and constants for the residual moments block.
// No dependencies; used by every other file except the macro header.
package fmrm_pkg;

  localparam int OPC_W      = 2;
  localparam int COL_W      = 10;
  localparam int SLOT_W     = 3;
  localparam int VAL_W      = 32;
  localparam int SUM_W      = 64;
  localparam int SQ_W       = 63;
  localparam int CCNT_W     = 4;
  localparam int CCOL_W     = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int N_W        = CCNT_W + 1;
  localparam int Q_DEPTH    = 2;

  localparam logic [SQ_W-1:0]  SQ_MAX  = {SQ_W{1'b1}};
  localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  localparam logic [CCNT_W-1:0] LATENT_RST  = 4'd1;
  localparam logic [CCNT_W-1:0] COVAR_RST   = 4'd1;
  localparam logic [CCOL_W-1:0] COLUMNS_RST = 11'd1024;

  typedef enum logic [OPC_W-1:0] {
    OP_LOAD_COL = 2'd0,
    OP_LOAD_ROW = 2'd1,
    OP_DATA     = 2'd2,
    OP_NONE     = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LATENT  = 2'd0,
    CFG_COVAR   = 2'd1,
    CFG_COLUMNS = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    op_e               op;
    logic [COL_W-1:0]  col;
    logic [SLOT_W-1:0] slot;
    logic              is_cov;
    logic [VAL_W-1:0]  value;
    logic              last;
    logic              act;
  } cmd_t;

  typedef struct packed {
    logic [CCNT_W-1:0] nk;
    logic [CCNT_W-1:0] nd;
  } cfg_t;

endpackage

>>> rtl/core/fmrm_if.sv
// Request and result channel interfaces (valid/ready).
// Depends on fmrm_pkg for field widths.
interface fmrm_in_if;
  logic                             valid;
  logic                             ready;
  logic [fmrm_pkg::OPC_W-1:0]       opcode;
  logic [fmrm_pkg::COL_W-1:0]       column_index;
  logic [fmrm_pkg::SLOT_W-1:0]      slot_index;
  logic                             is_covariate;
  logic signed [fmrm_pkg::VAL_W-1:0] value;
  logic                             last;

  modport source (output valid, opcode, column_index, slot_index, is_covariate, value, last,
                  input ready);
  modport sink   (input valid, opcode, column_index, slot_index, is_covariate, value, last,
                  output ready);
endinterface

interface fmrm_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [fmrm_pkg::SUM_W-1:0] residual_sum;
  logic [fmrm_pkg::SQ_W-1:0]         residual_square_sum;

  modport source (output valid, residual_sum, residual_square_sum, input ready);
  modport sink   (input valid, residual_sum, residual_square_sum, output ready);
endinterface

>>> rtl/core/factor_model_residual_moments.sv
// Channel      | Dir | Handshake    | Payload
// req_i        | in  | valid/ready  | opcode, column_index, slot_index, is_covariate, value, last
// rsp_o        | out | valid/ready  | residual_sum, residual_square_sum
// cfg_we_i     | in  | write enable | cfg_idx_i, cfg_data_i (no wait, no read-back)
//
// An in-range data element issues nk + nd dot-product terms on the one shared 32x32 multiplier,
// then the square terms unless |residual| >= 2^40 skips them; an element outside the columns
// in use is dropped, or if last goes straight to accumulation and leaves the sums unchanged.
// Reset clears control and both sums and presets config; the factor store is not cleared.
// A 2-entry request queue decouples accept from the back end; a held result only
// blocks the back end when the next result is ready.
module factor_model_residual_moments #(
  parameter int MAX_COLUMNS    = 1024,
  parameter int MAX_LATENT     = 8,
  parameter int MAX_COVARIATES = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  fmrm_in_if.sink                         req_i,
  fmrm_out_if.source                      rsp_o,
  input  logic                            cfg_we_i,
  input  logic [fmrm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [fmrm_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import fmrm_pkg::*;

  cmd_t push_data, pop_data;
  cfg_t cfg;
  logic push, full, pop, empty;

  fmrm_front #(
    .MAX_COLUMNS   (MAX_COLUMNS),
    .MAX_LATENT    (MAX_LATENT),
    .MAX_COVARIATES(MAX_COVARIATES)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_i),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .q_full_i  (full),
    .q_push_o  (push),
    .q_data_o  (push_data),
    .cfg_o     (cfg)
  );

  fmrm_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .full_o     (full),
    .pop_i      (pop),
    .pop_data_o (pop_data),
    .empty_o    (empty)
  );

  fmrm_back #(
    .MAX_COLUMNS   (MAX_COLUMNS),
    .MAX_LATENT    (MAX_LATENT),
    .MAX_COVARIATES(MAX_COVARIATES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (pop_data),
    .cmd_valid_i(!empty),
    .cmd_pop_o  (pop),
    .cfg_i      (cfg),
    .rsp_o      (rsp_o)
  );

endmodule

>>> rtl/core/fmrm_queue.sv
// Short command queue between front and back.
// Depends on fmrm_pkg (cmd_t, Q_DEPTH).
module fmrm_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  fmrm_pkg::cmd_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output fmrm_pkg::cmd_t pop_data_o,
  output logic           empty_o
);
  import fmrm_pkg::*;

  localparam int PtrW = $clog2(Q_DEPTH);

  cmd_t            entry_q [Q_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   fill_q, fill_d;

  assign full_o     = (fill_q == (PtrW+1)'(Q_DEPTH));
  assign empty_o    = (fill_q == '0);
  assign pop_data_o = entry_q[rd_ptr_q];

  always_comb begin
    fill_d = fill_q;
    if (push_i && !pop_i) begin
      fill_d = fill_q + 1'b1;
    end else if (pop_i && !push_i) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      fill_q <= fill_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> rtl/core/fmrm_front.sv
// Front end: config registers, request accept and classification.
// Depends on fmrm_pkg and fmrm_in_if; feeds fmrm_queue.
module fmrm_front #(
  parameter int MAX_COLUMNS    = 1024,
  parameter int MAX_LATENT     = 8,
  parameter int MAX_COVARIATES = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  fmrm_in_if.sink                         req_i,
  input  logic                            cfg_we_i,
  input  logic [fmrm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [fmrm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            q_full_i,
  output logic                            q_push_o,
  output fmrm_pkg::cmd_t                  q_data_o,
  output fmrm_pkg::cfg_t                  cfg_o
);
  import fmrm_pkg::*;

  logic [CCNT_W-1:0] latent_q, covar_q;
  logic [CCOL_W-1:0] columns_q;
  logic [31:0]       ncol;
  logic              slot_ok, keep, accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latent_q  <= LATENT_RST;
      covar_q   <= COVAR_RST;
      columns_q <= COLUMNS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_LATENT:  latent_q  <= cfg_data_i[CCNT_W-1:0];
        CFG_COVAR:   covar_q   <= cfg_data_i[CCNT_W-1:0];
        CFG_COLUMNS: columns_q <= cfg_data_i[CCOL_W-1:0];
        default: ;
      endcase
    end
  end

  // counts saturate at the configured maxima
  assign cfg_o.nk = (32'(latent_q) > MAX_LATENT)    ? CCNT_W'(MAX_LATENT)     : latent_q;
  assign cfg_o.nd = (32'(covar_q)  > MAX_COVARIATES) ? CCNT_W'(MAX_COVARIATES) : covar_q;
  assign ncol     = (32'(columns_q) > MAX_COLUMNS)   ? 32'(MAX_COLUMNS)       : 32'(columns_q);

  assign slot_ok = req_i.is_covariate ? (32'(req_i.slot_index) < MAX_COVARIATES)
                                      : (32'(req_i.slot_index) < MAX_LATENT);

  always_comb begin
    q_data_o.op     = op_e'(req_i.opcode);
    q_data_o.col    = req_i.column_index;
    q_data_o.slot   = req_i.slot_index;
    q_data_o.is_cov = req_i.is_covariate;
    q_data_o.value  = req_i.value;
    q_data_o.last   = req_i.last;
    q_data_o.act    = (32'(req_i.column_index) < ncol);
    case (op_e'(req_i.opcode))
      OP_LOAD_COL: keep = slot_ok && (32'(req_i.column_index) < MAX_COLUMNS);
      OP_LOAD_ROW: keep = slot_ok;
      OP_DATA:     keep = q_data_o.act || req_i.last;
      default:     keep = 1'b0;
    endcase
  end

  assign req_i.ready = !q_full_i;
  assign accept      = req_i.valid && req_i.ready;
  assign q_push_o    = accept && keep;

endmodule

>>> rtl/core/fmrm_back.sv
// Back end: factor store, shared multiply pipeline, residual moments and result register.
// Depends on fmrm_pkg and fmrm_out_if; drains fmrm_queue.
module fmrm_back #(
  parameter int MAX_COLUMNS    = 1024,
  parameter int MAX_LATENT     = 8,
  parameter int MAX_COVARIATES = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  fmrm_pkg::cmd_t cmd_i,
  input  logic           cmd_valid_i,
  output logic           cmd_pop_o,
  input  fmrm_pkg::cfg_t cfg_i,
  fmrm_out_if.source     rsp_o
);
  import fmrm_pkg::*;

  localparam int Slots = MAX_LATENT + MAX_COVARIATES;
  localparam int Depth = MAX_COLUMNS * Slots;
  localparam int AddrW = $clog2(Depth);
  localparam int PosW  = $clog2(Slots);
  localparam int ResW  = 48 + $clog2(Slots + 1);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_ISSUE = 6'b000010,
    ST_DRAIN = 6'b000100,
    ST_SQ    = 6'b001000,
    ST_FLUSH = 6'b010000,
    ST_ACC   = 6'b100000
  } state_e;

  typedef enum logic [1:0] {
    TAG_DOT = 2'd0,
    TAG_HH  = 2'd1,
    TAG_HL  = 2'd2,
    TAG_LL  = 2'd3
  } tag_e;

  state_e state_q, state_d;

  logic [VAL_W-1:0] mem [Depth];
  logic [VAL_W-1:0] row_q [Slots];

  logic [N_W-1:0]   cnt_q, cnt_d, n_total;
  tag_e             sq_tag_q, sq_tag_d;
  logic [COL_W-1:0] col_q;
  logic             act_q, last_q;

  logic [PosW-1:0]  issue_pos, ld_pos;
  logic [AddrW-1:0] rd_addr, wr_addr;
  logic             mem_we, row_we, pop_data;

  logic signed [VAL_W-1:0]   mem_rd_q, row_rd_q, sq_a_q, sq_b_q, mul_a, mul_b;
  logic signed [2*VAL_W-1:0] prod_q;
  logic                      p1_q, p2_q, p1_d;
  tag_e                      p1_tag_q, p2_tag_q, p1_tag_d;

  logic signed [ResW-1:0] res_q;
  logic [ResW-1:0]        mag;
  logic                   mag_big, big_q;
  logic [19:0]            hi_q, lo_q;
  logic [63:0]            sq_sum_q;
  logic signed [47:0]     term;
  logic                   pipe_empty;

  logic [SUM_W-1:0] sum_acc_q, sum_new, sum_upd, out_sum_q;
  logic [SUM_W:0]   sum_ext;
  logic [SQ_W-1:0]  sq_acc_q, q_sq, sq_new, sq_upd, out_sq_q;
  logic [SQ_W:0]    sq_ext;
  logic             out_valid_q, acc_fire;

  // ---------------- addressing ----------------
  assign n_total   = {1'b0, cfg_i.nk} + {1'b0, cfg_i.nd};
  assign issue_pos = (cnt_q < {1'b0, cfg_i.nk}) ? PosW'(cnt_q)
                   : PosW'(MAX_LATENT + 32'(cnt_q) - 32'(cfg_i.nk));
  assign ld_pos    = cmd_i.is_cov ? PosW'(MAX_LATENT + 32'(cmd_i.slot)) : PosW'(cmd_i.slot);
  assign rd_addr   = AddrW'(32'(col_q) * Slots) + AddrW'(issue_pos);
  assign wr_addr   = AddrW'(32'(cmd_i.col) * Slots) + AddrW'(ld_pos);

  assign cmd_pop_o = (state_q == ST_IDLE) && cmd_valid_i;
  assign mem_we    = cmd_pop_o && (cmd_i.op == OP_LOAD_COL);
  assign row_we    = cmd_pop_o && (cmd_i.op == OP_LOAD_ROW);
  assign pop_data  = cmd_pop_o && (cmd_i.op == OP_DATA);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= cmd_i.value;
    end
    mem_rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (row_we) begin
      row_q[ld_pos] <= cmd_i.value;
    end
    row_rd_q <= row_q[issue_pos];
  end

  // ---------------- sequencer ----------------
  assign pipe_empty = !p1_q && !p2_q;
  assign mag        = res_q[ResW-1] ? ResW'(-res_q) : ResW'(res_q);
  assign mag_big    = |mag[ResW-1:40];
  assign acc_fire   = (state_q == ST_ACC) && (!last_q || !out_valid_q || rsp_o.ready);

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    sq_tag_d = sq_tag_q;
    p1_d     = 1'b0;
    p1_tag_d = TAG_DOT;
    case (state_q)
      ST_IDLE: begin
        cnt_d    = '0;
        sq_tag_d = TAG_HH;
        if (pop_data) begin
          if (!cmd_i.act) begin
            state_d = ST_ACC;
          end else if (n_total == '0) begin
            state_d = ST_DRAIN;
          end else begin
            state_d = ST_ISSUE;
          end
        end
      end
      ST_ISSUE: begin
        p1_d  = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == n_total - 1'b1) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (pipe_empty) begin
          state_d = mag_big ? ST_ACC : ST_SQ;
        end
      end
      ST_SQ: begin
        p1_d     = 1'b1;
        p1_tag_d = sq_tag_q;
        sq_tag_d = tag_e'(sq_tag_q + 1'b1);
        if (sq_tag_q == TAG_LL) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (pipe_empty) begin
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        if (acc_fire) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      sq_tag_q <= TAG_HH;
      p1_q     <= 1'b0;
      p2_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      sq_tag_q <= sq_tag_d;
      p1_q     <= p1_d;
      p2_q     <= p1_q;
    end
  end

  // ---------------- multiply pipeline ----------------
  assign mul_a = (p1_tag_q == TAG_DOT) ? mem_rd_q : sq_a_q;
  assign mul_b = (p1_tag_q == TAG_DOT) ? row_rd_q : sq_b_q;
  assign term  = prod_q[63:16];

  always_ff @(posedge clk_i) begin
    p1_tag_q <= p1_tag_d;
    p2_tag_q <= p1_tag_q;
    sq_a_q   <= {12'b0, (sq_tag_q == TAG_LL) ? lo_q : hi_q};
    sq_b_q   <= {12'b0, (sq_tag_q == TAG_HH) ? hi_q : lo_q};
    prod_q   <= mul_a * mul_b;
    if (pop_data) begin
      col_q  <= cmd_i.col;
      act_q  <= cmd_i.act;
      last_q <= cmd_i.last;
      res_q  <= ResW'(signed'(cmd_i.value));
    end else if (p2_q && (p2_tag_q == TAG_DOT)) begin
      res_q <= res_q - ResW'(term);
    end
    if (state_q == ST_DRAIN && pipe_empty) begin
      big_q    <= mag_big;
      hi_q     <= mag[39:20];
      lo_q     <= mag[19:0];
      sq_sum_q <= '0;
    end else if (p2_q) begin
      case (p2_tag_q)
        TAG_HH:  sq_sum_q <= sq_sum_q + {prod_q[39:0], 24'b0};
        TAG_HL:  sq_sum_q <= sq_sum_q + {prod_q[58:0], 5'b0};
        TAG_LL:  sq_sum_q <= sq_sum_q + {16'b0, prod_q[63:16]};
        default: ;
      endcase
    end
  end

  // ---------------- moments ----------------
  assign sum_ext = {sum_acc_q[SUM_W-1], sum_acc_q} + (SUM_W+1)'(res_q);
  assign sum_new = (sum_ext[SUM_W] != sum_ext[SUM_W-1])
                 ? (sum_ext[SUM_W] ? SUM_MIN : SUM_MAX) : sum_ext[SUM_W-1:0];
  assign q_sq    = (big_q || sq_sum_q[63]) ? SQ_MAX : sq_sum_q[SQ_W-1:0];
  assign sq_ext  = {1'b0, sq_acc_q} + {1'b0, q_sq};
  assign sq_new  = sq_ext[SQ_W] ? SQ_MAX : sq_ext[SQ_W-1:0];
  assign sum_upd = act_q ? sum_new : sum_acc_q;
  assign sq_upd  = act_q ? sq_new : sq_acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_acc_q   <= '0;
      sq_acc_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (acc_fire) begin
        sum_acc_q <= last_q ? '0 : sum_upd;
        sq_acc_q  <= last_q ? '0 : sq_upd;
      end
      if (acc_fire && last_q) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_fire && last_q) begin
      out_sum_q <= sum_upd;
      out_sq_q  <= sq_upd;
    end
  end

  assign rsp_o.valid               = out_valid_q;
  assign rsp_o.residual_sum        = out_sum_q;
  assign rsp_o.residual_square_sum = out_sq_q;

endmodule

>>> rtl/core/fmrm_checker.sv
// Port-level checks for the residual moments block, bound to the top level.
// Depends on fmrm_pkg and the assertion macro header.
`include "factor_model_residual_moments_defines.svh"

module fmrm_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       req_valid_i,
  input logic                       req_ready_i,
  input logic                       rsp_valid_i,
  input logic                       rsp_ready_i,
  input logic [fmrm_pkg::SUM_W-1:0] rsp_sum_i,
  input logic [fmrm_pkg::SQ_W-1:0]  rsp_sq_i
);

  `FMRM_ASSERT_NEXT(a_rsp_hold, rsp_valid_i && !rsp_ready_i, rsp_valid_i, "result dropped while stalled")
  `FMRM_ASSERT_NEXT(a_rsp_stable, rsp_valid_i && !rsp_ready_i, $stable(rsp_sum_i) && $stable(rsp_sq_i), "result changed while stalled")
  `FMRM_ASSERT_NOW(a_ready_fall, $fell(req_ready_i), $past(req_valid_i && req_ready_i), "ready fell without a request")
  `FMRM_ASSERT_NEXT(a_ready_keep, req_ready_i && !req_valid_i, req_ready_i, "ready fell while idle")

endmodule

bind factor_model_residual_moments fmrm_checker u_fmrm_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .req_valid_i(req_i.valid),
  .req_ready_i(req_i.ready),
  .rsp_valid_i(rsp_o.valid),
  .rsp_ready_i(rsp_o.ready),
  .rsp_sum_i  (rsp_o.residual_sum),
  .rsp_sq_i   (rsp_o.residual_square_sum)
);
